FILE: hdl/lcpw_pkg.sv
// Shared types and constants for the LRU cache directory with a pinned window.
// Used by the top level and by its port checker; depends on nothing else.

package lcpw_pkg;

  localparam int unsigned CAPACITY_DEF   = 512;
  localparam int unsigned INDEX_BITS_DEF = 20;
  localparam int unsigned ACTION_W       = 3;
  localparam int unsigned STATUS_W       = 3;
  localparam int unsigned SLOT_OUT_W     = 9;
  localparam int unsigned EPOCH_W        = 16;
  localparam int unsigned STAMP_W        = 64;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR      = 3'd0,
    ACT_SET_WINDOW = 3'd1,
    ACT_VISIT      = 3'd2,
    ACT_INSERT     = 3'd3,
    ACT_LOOKUP     = 3'd4
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 3'd0,
    ST_HIT    = 3'd1,
    ST_MISS   = 3'd2,
    ST_STORED = 3'd3,
    ST_STALE  = 3'd4,
    ST_FULL   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    FSM_INIT,
    FSM_IDLE,
    FSM_CLEAR,
    FSM_SCAN,
    FSM_DRAIN,
    FSM_DECIDE
  } fsm_e;

endpackage

FILE: hdl/lru_cache_with_pinned_window.sv
// Fully associative LRU cache directory with a pinned index window.
// Depends on lcpw_pkg; the directory store is a memory with one write and one read port inside this module.

// Usage: a command word is taken at a rising edge where start_i is high and busy_o is
// low. Each command produces exactly one result word, shown for one cycle with done_o
// high; the receiver cannot stall, so it must sample every result as it appears. Set
// window, unknown actions and inserts that are stale or outside the window finish at
// once: done_o rises in the cycle after the accepting edge and busy_o stays low. Visit,
// lookup and a valid insert scan the whole store through its read port, one entry per
// cycle, then pass through a drain and a decide state; the result is registered in the
// decide state; the next command can be taken once the block is back in idle. Clear
// writes every entry invalid, one per cycle, and reports when the last is written.
// After reset the block runs a clearing pass with busy_o high before its first word.
// A hit on visit or insert stamps the entry with the next value of a 64-bit use clock.
// On a full store, the victim is the valid entry outside the current window with the
// oldest stamp, ties going to the lowest item index; the scan tracks the matching
// entry, the lowest free slot and that victim all in one pass, with one stamp compare
// per cycle. current_epoch_o always shows the epoch, which advances on every clear.

module lru_cache_with_pinned_window #(
  parameter int unsigned CAPACITY   = lcpw_pkg::CAPACITY_DEF,
  parameter int unsigned INDEX_BITS = lcpw_pkg::INDEX_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [lcpw_pkg::ACTION_W-1:0]     action_i,
  input  logic [INDEX_BITS-1:0]             item_index_i,
  input  logic [INDEX_BITS:0]               window_first_i,
  input  logic [INDEX_BITS:0]               window_end_i,
  input  logic [lcpw_pkg::EPOCH_W-1:0]      request_epoch_i,
  output logic                              done_o,
  output logic [lcpw_pkg::STATUS_W-1:0]     status_o,
  output logic [lcpw_pkg::SLOT_OUT_W-1:0]   slot_o,
  output logic                              evicted_o,
  output logic [INDEX_BITS-1:0]             evicted_index_o,
  output logic [lcpw_pkg::EPOCH_W-1:0]      current_epoch_o
);

  import lcpw_pkg::*;

  localparam int unsigned SLOT_W = $clog2(CAPACITY);
  localparam int unsigned WORD_W = 1 + INDEX_BITS + STAMP_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);

  // Store word layout: valid bit on top, then the item index, then the use stamp.
  logic [WORD_W-1:0] store_mem [CAPACITY];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  fsm_e state_q, state_d;
  logic [SLOT_W-1:0] addr_q, addr_d;
  logic              rd_vld_q, rd_vld_d;
  logic [SLOT_W-1:0] rd_slot_q;

  logic [STAMP_W-1:0]    clock_q, clock_d;
  logic [EPOCH_W-1:0]    epoch_q, epoch_d;
  logic [INDEX_BITS:0]   pin_first_q, pin_first_d;
  logic [INDEX_BITS:0]   pin_end_q, pin_end_d;

  action_e               act_q, act_d;
  logic [INDEX_BITS-1:0] item_q, item_d;

  // Scan trackers.
  logic                  hit_found_q, hit_found_d;
  logic [SLOT_W-1:0]     hit_slot_q, hit_slot_d;
  logic                  free_found_q, free_found_d;
  logic [SLOT_W-1:0]     free_slot_q, free_slot_d;
  logic                  vic_found_q, vic_found_d;
  logic [SLOT_W-1:0]     vic_slot_q, vic_slot_d;
  logic [INDEX_BITS-1:0] vic_item_q, vic_item_d;
  logic [STAMP_W-1:0]    vic_stamp_q, vic_stamp_d;

  // Result word registers.
  logic                  done_q, done_d;
  status_e               status_q, status_d;
  logic [SLOT_OUT_W-1:0] slot_q, slot_d;
  logic                  evicted_q, evicted_d;
  logic [INDEX_BITS-1:0] evidx_q, evidx_d;

  logic                  accept;
  logic                  addr_last;
  logic                  insert_stale;
  logic                  rd_valid_bit;
  logic [INDEX_BITS-1:0] rd_item;
  logic [STAMP_W-1:0]    rd_stamp;
  logic                  rd_pinned;
  logic                  rd_older;
  logic [STAMP_W-1:0]    clock_next;
  logic                  do_touch;
  logic [SLOT_W-1:0]     touch_slot;

  assign busy_o    = (state_q != FSM_IDLE);
  assign accept    = start_i && !busy_o;
  assign addr_last = (addr_q == LAST_SLOT);

  assign insert_stale = (request_epoch_i != epoch_q)
                     || ({1'b0, item_index_i} < pin_first_q)
                     || ({1'b0, item_index_i} >= pin_end_q);

  assign rd_valid_bit = rdata_q[WORD_W-1];
  assign rd_item      = rdata_q[STAMP_W +: INDEX_BITS];
  assign rd_stamp     = rdata_q[STAMP_W-1:0];
  assign rd_pinned    = ({1'b0, rd_item} >= pin_first_q) && ({1'b0, rd_item} < pin_end_q);
  assign rd_older     = (rd_stamp < vic_stamp_q)
                     || ((rd_stamp == vic_stamp_q) && (rd_item < vic_item_q));
  assign clock_next   = clock_q + STAMP_W'(1);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_INIT, FSM_CLEAR: begin
        if (addr_last) state_d = FSM_IDLE;
      end
      FSM_IDLE: begin
        if (accept) begin
          if (action_i == ACT_CLEAR) begin
            state_d = FSM_CLEAR;
          end else if (action_i inside {ACT_VISIT, ACT_LOOKUP}) begin
            state_d = FSM_SCAN;
          end else if (action_i == ACT_INSERT && !insert_stale) begin
            state_d = FSM_SCAN;
          end
        end
      end
      FSM_SCAN: begin
        if (addr_last) state_d = FSM_DRAIN;
      end
      FSM_DRAIN:  state_d = FSM_DECIDE;
      FSM_DECIDE: state_d = FSM_IDLE;
      default:    state_d = FSM_IDLE;
    endcase
  end

  // Sequencer outputs, scan trackers and result word.
  always_comb begin
    addr_d       = addr_q;
    rd_vld_d     = 1'b0;
    clock_d      = clock_q;
    epoch_d      = epoch_q;
    pin_first_d  = pin_first_q;
    pin_end_d    = pin_end_q;
    act_d        = act_q;
    item_d       = item_q;
    hit_found_d  = hit_found_q;
    hit_slot_d   = hit_slot_q;
    free_found_d = free_found_q;
    free_slot_d  = free_slot_q;
    vic_found_d  = vic_found_q;
    vic_slot_d   = vic_slot_q;
    vic_item_d   = vic_item_q;
    vic_stamp_d  = vic_stamp_q;
    done_d       = 1'b0;
    status_d     = status_q;
    slot_d       = slot_q;
    evicted_d    = evicted_q;
    evidx_d      = evidx_q;
    mem_we       = 1'b0;
    mem_waddr    = addr_q;
    mem_wdata    = '0;
    do_touch     = 1'b0;
    touch_slot   = '0;

    // Fold the word read in the previous cycle into the trackers.
    if (rd_vld_q) begin
      if (rd_valid_bit && rd_item == item_q && !hit_found_q) begin
        hit_found_d = 1'b1;
        hit_slot_d  = rd_slot_q;
      end
      if (!rd_valid_bit && !free_found_q) begin
        free_found_d = 1'b1;
        free_slot_d  = rd_slot_q;
      end
      if (rd_valid_bit && !rd_pinned && (!vic_found_q || rd_older)) begin
        vic_found_d = 1'b1;
        vic_slot_d  = rd_slot_q;
        vic_item_d  = rd_item;
        vic_stamp_d = rd_stamp;
      end
    end

    case (state_q)
      FSM_INIT, FSM_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        addr_d    = addr_last ? '0 : addr_q + SLOT_W'(1);
        if (state_q == FSM_CLEAR && addr_last) begin
          done_d    = 1'b1;
          status_d  = ST_DONE;
          slot_d    = '0;
          evicted_d = 1'b0;
          evidx_d   = '0;
        end
      end
      FSM_IDLE: begin
        if (accept) begin
          act_d        = action_e'(action_i);
          item_d       = item_index_i;
          hit_found_d  = 1'b0;
          free_found_d = 1'b0;
          vic_found_d  = 1'b0;
          status_d     = ST_DONE;
          slot_d       = '0;
          evicted_d    = 1'b0;
          evidx_d      = '0;
          case (action_i)
            ACT_CLEAR: begin
              epoch_d = epoch_q + EPOCH_W'(1);
            end
            ACT_SET_WINDOW: begin
              pin_first_d = window_first_i;
              pin_end_d   = window_end_i;
              done_d      = 1'b1;
            end
            ACT_INSERT: begin
              if (insert_stale) begin
                done_d   = 1'b1;
                status_d = ST_STALE;
              end
            end
            ACT_VISIT, ACT_LOOKUP: begin
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      FSM_SCAN: begin
        rd_vld_d = 1'b1;
        addr_d   = addr_last ? '0 : addr_q + SLOT_W'(1);
      end
      FSM_DRAIN: begin
      end
      FSM_DECIDE: begin
        done_d    = 1'b1;
        slot_d    = '0;
        evicted_d = 1'b0;
        evidx_d   = '0;
        if (act_q == ACT_INSERT) begin
          status_d = ST_STORED;
          if (hit_found_q) begin
            do_touch   = 1'b1;
            touch_slot = hit_slot_q;
          end else if (free_found_q) begin
            do_touch   = 1'b1;
            touch_slot = free_slot_q;
          end else if (vic_found_q) begin
            do_touch   = 1'b1;
            touch_slot = vic_slot_q;
            evicted_d  = 1'b1;
            evidx_d    = vic_item_q;
          end else begin
            status_d = ST_FULL;
          end
        end else if (hit_found_q) begin
          status_d   = ST_HIT;
          touch_slot = hit_slot_q;
          do_touch   = (act_q == ACT_VISIT);
          slot_d     = SLOT_OUT_W'(hit_slot_q);
        end else begin
          status_d = ST_MISS;
        end
        if (do_touch) begin
          clock_d   = clock_next;
          mem_we    = 1'b1;
          mem_waddr = touch_slot;
          mem_wdata = {1'b1, item_q, clock_next};
          slot_d    = SLOT_OUT_W'(touch_slot);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FSM_INIT;
      addr_q       <= '0;
      rd_vld_q     <= 1'b0;
      clock_q      <= '0;
      epoch_q      <= '0;
      pin_first_q  <= '0;
      pin_end_q    <= '0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      vic_found_q  <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      addr_q       <= addr_d;
      rd_vld_q     <= rd_vld_d;
      clock_q      <= clock_d;
      epoch_q      <= epoch_d;
      pin_first_q  <= pin_first_d;
      pin_end_q    <= pin_end_d;
      hit_found_q  <= hit_found_d;
      free_found_q <= free_found_d;
      vic_found_q  <= vic_found_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_slot_q   <= addr_q;
    act_q       <= act_d;
    item_q      <= item_d;
    hit_slot_q  <= hit_slot_d;
    free_slot_q <= free_slot_d;
    vic_slot_q  <= vic_slot_d;
    vic_item_q  <= vic_item_d;
    vic_stamp_q <= vic_stamp_d;
    status_q    <= status_d;
    slot_q      <= slot_d;
    evicted_q   <= evicted_d;
    evidx_q     <= evidx_d;
  end

  // Directory store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= store_mem[addr_q];
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign slot_o          = slot_q;
  assign evicted_o       = evicted_q;
  assign evicted_index_o = evidx_q;
  assign current_epoch_o = epoch_q;

endmodule

FILE: hdl/lcpw_checker.sv
// Port-level checker for the LRU cache directory, bound to the top level.
// Depends on lcpw_pkg and on the port list of lru_cache_with_pinned_window.

module lcpw_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start_i,
  input logic                              busy_o,
  input logic [lcpw_pkg::ACTION_W-1:0]     action_i,
  input logic [lcpw_pkg::EPOCH_W-1:0]      request_epoch_i,
  input logic                              done_o,
  input logic [lcpw_pkg::STATUS_W-1:0]     status_o,
  input logic [lcpw_pkg::SLOT_OUT_W-1:0]   slot_o,
  input logic                              evicted_o,
  input logic [lcpw_pkg::EPOCH_W-1:0]      current_epoch_o
);

  import lcpw_pkg::*;

  logic accept;
  assign accept = start_i && !busy_o;

  // A clear advances the epoch by exactly one.
  a_clear_epoch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && action_i == ACT_CLEAR |=> current_epoch_o == $past(current_epoch_o) + 16'd1)
    else $error("clear did not advance the epoch by one");

  // Setting the window reports done in the next cycle.
  a_window_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && action_i == ACT_SET_WINDOW |=> done_o && status_o == ST_DONE)
    else $error("set window did not report done at once");

  // An insert carrying a different epoch is dropped at once.
  a_stale_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && action_i == ACT_INSERT && request_epoch_i != current_epoch_o
    |=> done_o && status_o == ST_STALE)
    else $error("insert with a stale epoch was not dropped");

  // Only a stored insert can report an eviction.
  a_evict_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && evicted_o |-> status_o == ST_STORED)
    else $error("eviction reported on a result that is not stored");

  // Results without a slot report slot zero.
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_MISS || status_o == ST_STALE || status_o == ST_FULL
               || status_o == ST_DONE) |-> slot_o == '0)
    else $error("slot not zero on a result without a slot");

endmodule

bind lru_cache_with_pinned_window lcpw_checker u_lcpw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .action_i        (action_i),
  .request_epoch_i (request_epoch_i),
  .done_o          (done_o),
  .status_o        (status_o),
  .slot_o          (slot_o),
  .evicted_o       (evicted_o),
  .current_epoch_o (current_epoch_o)
);
